/* rtl/nlms_pkg.sv */
// nlms_pkg: shared types and constants for the nlms adaptive fir filter
package nlms_pkg;

    localparam int WEIGHT_W   = 32;   // weights, q2.30
    localparam int STEP_W     = 16;   // step size, q0.16
    localparam int REGL_W     = 32;   // regularizer
    localparam int ACC_W      = 64;   // dot product and energy accumulators
    localparam int DIV_W      = 64;   // divider operand width
    localparam int Q_W        = 47;   // scaled step magnitude
    localparam int MUL_A_W    = 48;   // wide operand of the shared multiplier
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int EST_SHIFT  = 30;
    localparam int NUM_SHIFT  = 29;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd3277;
    localparam logic [REGL_W-1:0] REGL_RESET = 32'd1074;
    localparam logic [Q_W-1:0]    STEP_CAP   = {Q_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGULARIZER = 8'd1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SQ_OLD,
        ST_SQ_NEW,
        ST_SQ_END,
        ST_DOT,
        ST_EST,
        ST_NUM,
        ST_NUM_WAIT,
        ST_DIV,
        ST_UPD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

endpackage

/* rtl/nlms_ram.sv */
// nlms_ram: generic single-write, single-read ram with registered read data
module nlms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/nlms_mul.sv */
// nlms_mul: shared signed multiplier with a registered product
module nlms_mul #(
    parameter int A_W = 48,
    parameter int B_W = 17
) (
    input  logic                        aclk,
    input  logic signed [A_W-1:0]       a,
    input  logic signed [B_W-1:0]       b,
    output logic signed [A_W+B_W-1:0]   p
);

    logic signed [A_W+B_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

/* rtl/nlms_div.sv */
// nlms_div: restoring unsigned divider, one quotient bit per cycle
module nlms_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  nlms_pkg::div_req_t            req,
    output logic [nlms_pkg::DIV_W-1:0]    quotient,
    output logic                          done
);

    localparam int W  = nlms_pkg::DIV_W;
    localparam int SW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [SW-1:0] step_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  den_reg;

    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == SW'(W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[W-1:0] : trial[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

/* rtl/nlms_adaptive_fir_filter.sv */
// nlms_adaptive_fir_filter: normalized lms adaptive fir filter, top level
//
//  channel   dir   handshake          payload
//  s_*       in    s_tvalid/s_tready  tdata {reference, sample_in}, tuser adapt
//  m_*       out   m_tvalid/m_tready  tdata {error, estimate}
//  cfg_*     in    cfg_valid/cfg_ready index 0 step_size, 1 regularizer
//
//  each beat runs a dot pass; with adapt high it then waits on the divider and
//  runs an update pass. both passes feed one tap per cycle through the shared
//  multiplier. after reset a clearing pass zeroes both rams; s_tready low.
//  a finished result sits in the output register and the next beat is taken
//  while it waits; the sequencer holds in its output state while an older
//  result is unaccepted. config writes are taken in any cycle.
module nlms_adaptive_fir_filter #(
    parameter int TAPS        = 512,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // sample_in, reference, zero pad
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    // adapt
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // estimate, error, zero pad
    output logic [((2*SAMPLE_BITS+8)/8)*8-1:0]    m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [nlms_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nlms_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int S     = SAMPLE_BITS;
    localparam int PW    = $clog2(TAPS);
    localparam int CW    = PW + 1;
    localparam int OUT_W = ((2*SAMPLE_BITS+8)/8)*8;
    localparam int A_W   = nlms_pkg::MUL_A_W;
    localparam int B_W   = S + 1;
    localparam int P_W   = A_W + B_W;
    localparam int ACC_W = nlms_pkg::ACC_W;
    localparam int WW    = nlms_pkg::WEIGHT_W;
    localparam int QW    = nlms_pkg::Q_W;
    localparam int DW    = QW + 1;
    localparam int SUM_W = DW + 2;

    nlms_pkg::state_t state_reg, state_next;

    logic [CW-1:0]               cnt_reg;
    logic [PW-1:0]               idx_reg;
    logic [PW-1:0]               wpos_reg;
    logic signed [S-1:0]         sample_reg;
    logic signed [S-1:0]         ref_reg;
    logic                        adapt_reg;
    logic [ACC_W-1:0]            energy_reg;
    logic [ACC_W-1:0]            acc_reg;
    logic signed [S-1:0]         est_reg;
    logic signed [S:0]           err_reg;
    logic [QW-1:0]               q_reg;
    logic                        d1_reg;
    logic                        d2_reg;
    logic [PW-1:0]               k_d1_reg;
    logic [PW-1:0]               k_d2_reg;
    logic signed [WW-1:0]        w_d2_reg;
    logic                        neg_d2_reg;
    logic [nlms_pkg::STEP_W-1:0] step_reg;
    logic [nlms_pkg::REGL_W-1:0] regl_reg;
    logic                        m_valid_reg;
    logic signed [S-1:0]         m_est_reg;
    logic signed [S:0]           m_err_reg;

    logic                        accept;
    logic                        issue;
    logic                        pass_done;
    logic                        load_out;
    logic [PW-1:0]               pos_inc;
    logic [PW-1:0]               idx_inc;

    logic                        h_we;
    logic [PW-1:0]               h_waddr;
    logic [S-1:0]                h_wdata;
    logic [PW-1:0]               h_raddr;
    logic signed [S-1:0]         h_rd;
    logic                        w_we;
    logic [PW-1:0]               w_waddr;
    logic [WW-1:0]               w_wdata;
    logic signed [WW-1:0]        w_rd;

    logic signed [A_W-1:0]       mul_a;
    logic signed [B_W-1:0]       mul_b;
    logic signed [P_W-1:0]       mul_p;
    logic [P_W-1:0]              mul_pu;
    logic [ACC_W-1:0]            p64;

    logic                        xneg;
    logic [S-1:0]                xmag;
    logic signed [S:0]           emag;

    logic signed [ACC_W-1:0]     est_full;
    logic [ACC_W-S:0]            est_hi;
    logic signed [S-1:0]         est_sat;
    logic signed [S:0]           err_calc;

    logic [DW-1:0]               dmag;
    logic signed [SUM_W-1:0]     sdelta;
    logic signed [SUM_W-1:0]     wsum;
    logic [SUM_W-WW:0]           wsum_hi;
    logic [WW-1:0]               w_new;

    nlms_pkg::div_req_t          div_req;
    logic [nlms_pkg::DIV_W-1:0]  div_quo;
    logic                        div_done;
    logic [ACC_W-1:0]            den_raw;

    nlms_ram #(.WIDTH(S), .DEPTH(TAPS)) u_hist_ram (
        .aclk  (aclk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rd)
    );

    nlms_ram #(.WIDTH(WW), .DEPTH(TAPS)) u_weight_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (cnt_reg[PW-1:0]),
        .rdata (w_rd)
    );

    nlms_mul #(.A_W(A_W), .B_W(B_W)) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    nlms_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign s_tready  = (state_reg == nlms_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = OUT_W'({m_err_reg, m_est_reg});

    assign pos_inc = (wpos_reg == PW'(TAPS - 1)) ? '0 : wpos_reg + 1'b1;
    assign idx_inc = (idx_reg == PW'(TAPS - 1)) ? '0 : idx_reg + 1'b1;
    assign issue   = (state_reg == nlms_pkg::ST_DOT || state_reg == nlms_pkg::ST_UPD)
                     && (cnt_reg != CW'(TAPS));
    assign pass_done = (cnt_reg == CW'(TAPS)) && !d1_reg && !d2_reg;
    assign load_out  = (state_reg == nlms_pkg::ST_OUT) && (!m_valid_reg || m_tready);

    assign mul_pu = mul_p;
    assign p64    = ACC_W'(mul_p);

    // history sample as magnitude and sign for the update pass
    assign xneg = h_rd[S-1];
    assign xmag = xneg ? S'(-h_rd) : S'(h_rd);
    assign emag = err_reg[S] ? -err_reg : err_reg;

    // estimate: floor shift, then saturate to the sample range
    assign est_full = $signed(acc_reg) >>> nlms_pkg::EST_SHIFT;
    assign est_hi   = est_full[ACC_W-1:S-1];
    always_comb begin
        if ((&est_hi) || !(|est_hi)) begin
            est_sat = est_full[S-1:0];
        end else begin
            est_sat = est_full[ACC_W-1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
        end
    end
    assign err_calc = {ref_reg[S-1], ref_reg} - {est_sat[S-1], est_sat};

    // weight update at the product stage
    assign dmag    = DW'(mul_pu >> (S - 1));
    assign sdelta  = neg_d2_reg ? -$signed({2'b00, dmag}) : $signed({2'b00, dmag});
    assign wsum    = SUM_W'(w_d2_reg) + sdelta;
    assign wsum_hi = wsum[SUM_W-1:WW-1];
    always_comb begin
        if ((&wsum_hi) || !(|wsum_hi)) begin
            w_new = wsum[WW-1:0];
        end else begin
            w_new = wsum[SUM_W-1] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
        end
    end

    assign den_raw = energy_reg + ACC_W'(regl_reg);

    // ram ports and multiplier operands
    always_comb begin
        h_we    = 1'b0;
        h_waddr = wpos_reg;
        h_wdata = sample_reg;
        w_we    = 1'b0;
        w_waddr = k_d2_reg;
        w_wdata = w_new;
        h_raddr = (state_reg == nlms_pkg::ST_IDLE) ? pos_inc : idx_reg;
        mul_a   = '0;
        mul_b   = '0;
        div_req.start = 1'b0;
        div_req.num   = p64 << nlms_pkg::NUM_SHIFT;
        div_req.den   = (den_raw == '0) ? ACC_W'(1) : den_raw;
        case (state_reg)
            nlms_pkg::ST_CLEAR: begin
                h_we    = 1'b1;
                h_waddr = cnt_reg[PW-1:0];
                h_wdata = '0;
                w_we    = 1'b1;
                w_waddr = cnt_reg[PW-1:0];
                w_wdata = '0;
            end
            nlms_pkg::ST_SQ_OLD: begin
                h_we  = 1'b1;
                mul_a = A_W'(h_rd);
                mul_b = B_W'(h_rd);
            end
            nlms_pkg::ST_SQ_NEW: begin
                mul_a = A_W'(sample_reg);
                mul_b = B_W'(sample_reg);
            end
            nlms_pkg::ST_DOT: begin
                mul_a = A_W'(w_rd);
                mul_b = B_W'(h_rd);
            end
            nlms_pkg::ST_NUM: begin
                mul_a = $signed(A_W'(step_reg));
                mul_b = emag;
            end
            nlms_pkg::ST_NUM_WAIT: begin
                div_req.start = 1'b1;
            end
            nlms_pkg::ST_UPD: begin
                mul_a = $signed(A_W'(q_reg));
                mul_b = $signed({1'b0, xmag});
                w_we  = d2_reg;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            nlms_pkg::ST_CLEAR: begin
                if (cnt_reg[PW-1:0] == PW'(TAPS - 1)) begin
                    state_next = nlms_pkg::ST_IDLE;
                end
            end
            nlms_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = nlms_pkg::ST_SQ_OLD;
                end
            end
            nlms_pkg::ST_SQ_OLD:   state_next = nlms_pkg::ST_SQ_NEW;
            nlms_pkg::ST_SQ_NEW:   state_next = nlms_pkg::ST_SQ_END;
            nlms_pkg::ST_SQ_END:   state_next = nlms_pkg::ST_DOT;
            nlms_pkg::ST_DOT: begin
                if (pass_done) begin
                    state_next = nlms_pkg::ST_EST;
                end
            end
            nlms_pkg::ST_EST: begin
                state_next = adapt_reg ? nlms_pkg::ST_NUM : nlms_pkg::ST_OUT;
            end
            nlms_pkg::ST_NUM:      state_next = nlms_pkg::ST_NUM_WAIT;
            nlms_pkg::ST_NUM_WAIT: state_next = nlms_pkg::ST_DIV;
            nlms_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = nlms_pkg::ST_UPD;
                end
            end
            nlms_pkg::ST_UPD: begin
                if (pass_done) begin
                    state_next = nlms_pkg::ST_OUT;
                end
            end
            nlms_pkg::ST_OUT: begin
                if (load_out) begin
                    state_next = nlms_pkg::ST_IDLE;
                end
            end
            default: state_next = nlms_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nlms_pkg::ST_CLEAR;
            cnt_reg     <= '0;
            wpos_reg    <= '0;
            energy_reg  <= '0;
            d1_reg      <= 1'b0;
            d2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            step_reg    <= nlms_pkg::STEP_RESET;
            regl_reg    <= nlms_pkg::REGL_RESET;
        end else begin
            state_reg <= state_next;
            d1_reg    <= issue;
            d2_reg    <= d1_reg;
            if (cfg_valid) begin
                case (cfg_index)
                    nlms_pkg::CFG_STEP_SIZE:   step_reg <= cfg_data[nlms_pkg::STEP_W-1:0];
                    nlms_pkg::CFG_REGULARIZER: regl_reg <= cfg_data[nlms_pkg::REGL_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                nlms_pkg::ST_CLEAR: begin
                    cnt_reg <= (cnt_reg[PW-1:0] == PW'(TAPS - 1)) ? '0 : cnt_reg + 1'b1;
                end
                nlms_pkg::ST_IDLE: begin
                    if (accept) begin
                        wpos_reg <= pos_inc;
                    end
                end
                nlms_pkg::ST_SQ_NEW: energy_reg <= energy_reg - p64;
                nlms_pkg::ST_SQ_END: begin
                    energy_reg <= energy_reg + p64;
                    cnt_reg    <= '0;
                end
                nlms_pkg::ST_DIV: begin
                    cnt_reg <= '0;
                end
                default: begin
                    if (issue) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        k_d1_reg   <= cnt_reg[PW-1:0];
        k_d2_reg   <= k_d1_reg;
        w_d2_reg   <= w_rd;
        neg_d2_reg <= err_reg[S] ^ xneg;
        if (issue) begin
            idx_reg <= idx_inc;
        end
        if (accept) begin
            sample_reg <= s_tdata[S-1:0];
            ref_reg    <= s_tdata[2*S-1:S];
            adapt_reg  <= s_tuser;
        end
        if (state_reg == nlms_pkg::ST_SQ_END) begin
            acc_reg <= '0;
            idx_reg <= wpos_reg;
        end
        if (state_reg == nlms_pkg::ST_DOT && d2_reg) begin
            acc_reg <= acc_reg + p64;
        end
        if (state_reg == nlms_pkg::ST_EST) begin
            est_reg <= est_sat;
            err_reg <= err_calc;
        end
        if (state_reg == nlms_pkg::ST_DIV && div_done) begin
            idx_reg <= wpos_reg;
            q_reg   <= (div_quo > nlms_pkg::DIV_W'(nlms_pkg::STEP_CAP))
                       ? nlms_pkg::STEP_CAP : div_quo[QW-1:0];
        end
        if (load_out) begin
            m_est_reg <= est_reg;
            m_err_reg <= err_reg;
        end
    end

endmodule
